@@ hdl/ikc_pkg.sv @@
// Shared types, constants, kernel table and finishing arithmetic for the convolution core.
package ikc_pkg;

    typedef logic signed [12:0] ikc_acc_t;

    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [2:0] MODE_BLUR        = 3'd0;
    localparam logic [2:0] MODE_SHARPEN     = 3'd1;
    localparam logic [2:0] MODE_EMBOSS      = 3'd2;
    localparam logic [2:0] MODE_NEGATIVE    = 3'd3;
    localparam logic [2:0] MODE_LIGHT_BLUR  = 3'd4;
    localparam logic [2:0] MODE_LIGHT_SHARP = 3'd5;
    localparam logic [2:0] MODE_LIGHT_EMB   = 3'd6;
    localparam logic [2:0] MODE_SPARE       = 3'd7;

    localparam logic [1:0] DIV_ONE  = 2'd0;
    localparam logic [1:0] DIV_FOUR = 2'd1;
    localparam logic [1:0] DIV_NINE = 2'd2;

    localparam logic [3:0] ADDR_MODE   = 4'h0;
    localparam logic [3:0] ADDR_WIDTH  = 4'h4;
    localparam logic [3:0] ADDR_HEIGHT = 4'h8;

    localparam logic [12:0] RECIP_NINE = 13'd7282;
    localparam ikc_acc_t    NEG_OFFSET = 13'sd256;

    typedef struct packed {
        logic                load;
        logic                offset;
        logic                step;
        logic signed [3:0]   weight;
        logic [1:0]          div_sel;
    } ikc_mac_ctrl_t;

    // [mode][column offset][row offset]
    localparam logic signed [3:0] KERN [8][3][3] = '{
        '{'{4'sd1, 4'sd1, 4'sd1}, '{4'sd1, 4'sd1, 4'sd1}, '{4'sd1, 4'sd1, 4'sd1}},
        '{'{4'sd0, -4'sd1, 4'sd0}, '{-4'sd1, 4'sd5, -4'sd1}, '{4'sd0, -4'sd1, 4'sd0}},
        '{'{-4'sd2, -4'sd1, 4'sd0}, '{-4'sd1, 4'sd1, 4'sd1}, '{4'sd0, 4'sd1, 4'sd2}},
        '{'{4'sd0, 4'sd0, 4'sd0}, '{4'sd0, -4'sd1, 4'sd0}, '{4'sd0, 4'sd0, 4'sd0}},
        '{'{4'sd1, 4'sd1, 4'sd0}, '{4'sd1, 4'sd1, 4'sd0}, '{4'sd0, 4'sd0, 4'sd0}},
        '{'{-4'sd1, 4'sd0, 4'sd0}, '{4'sd0, 4'sd2, 4'sd0}, '{4'sd0, 4'sd0, 4'sd0}},
        '{'{4'sd1, 4'sd0, 4'sd0}, '{4'sd0, 4'sd1, 4'sd0}, '{4'sd0, 4'sd0, -4'sd1}},
        '{'{4'sd1, 4'sd1, 4'sd1}, '{4'sd1, 4'sd1, 4'sd1}, '{4'sd1, 4'sd1, 4'sd1}}
    };

    function automatic logic signed [3:0] ikc_weight(logic [2:0] mode, logic [1:0] a,
                                                     logic [1:0] b);
        logic signed [3:0] w;
        w = 4'sd0;
        if (a < 2'd3 && b < 2'd3) begin
            w = KERN[mode][a][b];
        end
        return w;
    endfunction

    function automatic logic [1:0] ikc_div_sel(logic [2:0] mode);
        logic [1:0] sel;
        case (mode)
            MODE_BLUR, MODE_SPARE: sel = DIV_NINE;
            MODE_LIGHT_BLUR:       sel = DIV_FOUR;
            default:               sel = DIV_ONE;
        endcase
        return sel;
    endfunction

    // Floor division by the kernel sum, then saturation to 0..255.
    function automatic logic [7:0] ikc_finish(ikc_acc_t acc, logic [1:0] sel);
        logic [11:0] mag;
        logic [24:0] prod;
        logic [11:0] q;
        logic [7:0]  res;
        mag  = acc[11:0];
        prod = {13'b0, mag} * {12'b0, RECIP_NINE};
        case (sel)
            DIV_NINE: q = {3'b0, prod[24:16]};
            DIV_FOUR: q = {2'b0, mag[11:2]};
            default:  q = mag;
        endcase
        if (acc < 0) begin
            res = 8'd0;
        end else if (q > 12'd255) begin
            res = 8'd255;
        end else begin
            res = q[7:0];
        end
        return res;
    endfunction

endpackage

@@ hdl/ikc_frame_mem.sv @@
// Single-port synchronous frame store; read data is registered and appears in the cycle after the address.
module ikc_frame_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          aclk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [23:0]   wdata,
    output logic [23:0]   rdata
);

    logic [23:0] mem [DEPTH];
    logic [23:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ikc_mac.sv @@
// Per-channel weighted accumulation over the nine taps and result finishing.
module ikc_mac (
    input  logic                  aclk,
    input  ikc_pkg::ikc_mac_ctrl_t ctrl,
    input  logic [23:0]           pixel,
    output logic [23:0]           result
);

    import ikc_pkg::*;

    ikc_acc_t acc_reg  [3];
    ikc_acc_t acc_next [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc_next[c] = acc_reg[c];
            if (ctrl.load) begin
                acc_next[c] = ctrl.offset ? NEG_OFFSET : 13'sd0;
            end else if (ctrl.step) begin
                acc_next[c] = acc_reg[c] + ikc_acc_t'(ctrl.weight)
                              * $signed({5'b0, pixel[8*c +: 8]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            acc_reg[c] <= acc_next[c];
        end
    end

    // pixel packs blue low, red high; result packs red low
    assign result = {ikc_finish(acc_reg[0], ctrl.div_sel),
                     ikc_finish(acc_reg[1], ctrl.div_sel),
                     ikc_finish(acc_reg[2], ctrl.div_sel)};

endmodule

@@ hdl/image_kernel_convolution_core.sv @@
// 3x3 clamp-to-edge RGB convolution core: top level with sequencer and register port.
//
// Input stream (s_*): s_tuser selects the transaction kind, store or compute.
// A store transaction writes one RGB pixel into the frame store and leaves
// the core idle. A compute transaction names a centre pixel; the core reads its
// nine clamped neighbours from the single-port frame memory, one per cycle,
// and returns one filtered RGB pixel on the output stream (m_*).
// A compute transaction runs through the read state (nine memory reads),
// a drain state in which the last read's data accumulates, and a finish
// state that loads the result register. No new transaction is accepted
// until the core is back in idle.
// The next transaction is taken as soon as the result is registered, even
// while the receiver has not yet taken it; if the receiver stalls with a
// result still pending, the next compute waits at its finish step.
// The APB port sets kernel mode and image size; write only while idle.
// Reset (aresetn low, synchronous) returns the registers to blur mode and
// a 256x256 image and empties the output. Frame contents are undefined
// until written; no clearing pass is made.
module image_kernel_convolution_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // column, row, red_in, green_in, blue_in
    input  logic        s_tuser,  // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // red_out, green_out, blue_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import ikc_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    function automatic logic [8:0] used_size(logic [8:0] r, int maxv);
        logic [8:0] s;
        if (r == 9'd0) begin
            s = 9'd1;
        end else if ({23'b0, r} > maxv) begin
            s = 9'(maxv);
        end else begin
            s = r;
        end
        return s;
    endfunction

    function automatic logic [8:0] clamp_coord(logic [7:0] base, logic [1:0] d,
                                               logic [8:0] size);
        logic signed [9:0] v;
        logic signed [9:0] lim;
        logic [8:0]        c;
        v   = $signed({2'b00, base}) + $signed({8'b0, d}) - 10'sd1;
        lim = $signed({1'b0, size}) - 10'sd1;
        if (v < 0) begin
            c = 9'd0;
        end else if (v > lim) begin
            c = lim[8:0];
        end else begin
            c = v[8:0];
        end
        return c;
    endfunction

    logic [2:0]  mode_reg;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [1:0]  state_reg, state_next;
    logic [1:0]  tap_a_reg, tap_b_reg;
    logic        dly_valid_reg;
    logic [1:0]  dly_a_reg, dly_b_reg;
    logic [7:0]  col_reg, row_reg;
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    logic          cfg_wr;
    logic          s_acc;
    logic          store_ok;
    logic          mem_en, mem_we;
    logic [AW-1:0] mem_addr;
    logic [23:0]   mem_rdata;
    logic [8:0]    tap_cx, tap_ry;
    logic          last_tap;
    logic          fin_load;
    logic [23:0]   mac_result;
    ikc_mac_ctrl_t mac_ctrl;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_BLUR;
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end else if (cfg_wr) begin
            case (paddr)
                ADDR_MODE:   mode_reg   <= pwdata[2:0];
                ADDR_WIDTH:  width_reg  <= pwdata[8:0];
                ADDR_HEIGHT: height_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_MODE:   prdata = {29'b0, mode_reg};
            ADDR_WIDTH:  prdata = {23'b0, width_reg};
            ADDR_HEIGHT: prdata = {23'b0, height_reg};
            default:     prdata = 32'b0;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid & s_tready;
    assign store_ok = ({24'b0, s_tdata[7:0]} < MAX_WIDTH) &&
                      ({24'b0, s_tdata[15:8]} < MAX_HEIGHT);
    assign mem_we   = s_acc && (s_tuser == OP_STORE) && store_ok;
    assign mem_en   = mem_we || (state_reg == ST_READ);

    assign tap_cx = clamp_coord(col_reg, tap_a_reg, used_size(width_reg, MAX_WIDTH));
    assign tap_ry = clamp_coord(row_reg, tap_b_reg, used_size(height_reg, MAX_HEIGHT));

    always_comb begin
        if (state_reg == ST_READ) begin
            mem_addr = AW'(tap_ry * MAX_WIDTH + tap_cx);
        end else begin
            mem_addr = AW'(s_tdata[15:8] * MAX_WIDTH + s_tdata[7:0]);
        end
    end

    assign last_tap = (tap_a_reg == 2'd2) && (tap_b_reg == 2'd2);
    assign fin_load = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_tuser == OP_COMPUTE) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_FIN;
            ST_FIN: begin
                if (fin_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tap_a_reg     <= 2'd0;
            tap_b_reg     <= 2'd0;
            dly_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            dly_valid_reg <= (state_reg == ST_READ);
            if (state_reg == ST_READ) begin
                if (tap_b_reg == 2'd2) begin
                    tap_b_reg <= 2'd0;
                    tap_a_reg <= last_tap ? 2'd0 : tap_a_reg + 2'd1;
                end else begin
                    tap_b_reg <= tap_b_reg + 2'd1;
                end
            end
            if (fin_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dly_a_reg <= tap_a_reg;
        dly_b_reg <= tap_b_reg;
        if (s_acc && s_tuser == OP_COMPUTE) begin
            col_reg <= s_tdata[7:0];
            row_reg <= s_tdata[15:8];
        end
        if (fin_load) begin
            m_tdata_reg <= mac_result;
        end
    end

    always_comb begin
        mac_ctrl.load    = s_acc && (s_tuser == OP_COMPUTE);
        mac_ctrl.offset  = (mode_reg == MODE_NEGATIVE);
        mac_ctrl.step    = dly_valid_reg;
        mac_ctrl.weight  = ikc_weight(mode_reg, dly_a_reg, dly_b_reg);
        mac_ctrl.div_sel = ikc_div_sel(mode_reg);
    end

    ikc_frame_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_mem (
        .aclk (aclk),
        .en   (mem_en),
        .we   (mem_we),
        .addr (mem_addr),
        .wdata({s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]}),
        .rdata(mem_rdata)
    );

    ikc_mac u_mac (
        .aclk  (aclk),
        .ctrl  (mac_ctrl),
        .pixel (mem_rdata),
        .result(mac_result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_IDLE))
        else $error("frame write outside idle");

    a_drain_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> $past(state_reg == ST_READ) && $past(last_tap))
        else $error("drain entered before ninth tap");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside finish step");

    a_step_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        dly_valid_reg |-> $past(mem_en) && !$past(mem_we))
        else $error("accumulate without memory read");

endmodule

@@ test/conv_checker.sv @@
// Checker for the convolution core: predicts each filtered pixel and compares the result stream.
`timescale 1ns / 1ps
module conv_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          pending,
    output int          errors
);

    import ikc_pkg::*;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] row;
        logic [7:0] column;
    } pixel_req_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    // [mode][column offset][row offset]
    localparam int TAPS [8][3][3] = '{
        '{'{1, 1, 1}, '{1, 1, 1}, '{1, 1, 1}},
        '{'{0, -1, 0}, '{-1, 5, -1}, '{0, -1, 0}},
        '{'{-2, -1, 0}, '{-1, 1, 1}, '{0, 1, 2}},
        '{'{0, 0, 0}, '{0, -1, 0}, '{0, 0, 0}},
        '{'{1, 1, 0}, '{1, 1, 0}, '{0, 0, 0}},
        '{'{-1, 0, 0}, '{0, 2, 0}, '{0, 0, 0}},
        '{'{1, 0, 0}, '{0, 1, 0}, '{0, 0, -1}},
        '{'{1, 1, 1}, '{1, 1, 1}, '{1, 1, 1}}
    };

    logic [2:0]  mode_reg;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [23:0] frame [0:65535];  // {red, green, blue}
    rgb_t        filtered_due [$];

    function automatic int used_span(logic [8:0] v);
        int n;
        n = int'(v);
        if (n == 0) begin
            n = 1;
        end else if (n > 256) begin
            n = 256;
        end
        return n;
    endfunction

    function automatic int edge_clamp(int v, int lim);
        int r;
        r = v;
        if (r < 0) begin
            r = 0;
        end else if (r > lim - 1) begin
            r = lim - 1;
        end
        return r;
    endfunction

    function automatic logic [7:0] scale_channel(int acc, int div);
        int q;
        if (acc < 0) begin
            return 8'd0;
        end
        q = acc / div;
        if (q > 255) begin
            q = 255;
        end
        return q[7:0];
    endfunction

    function automatic rgb_t filter_pixel(logic [7:0] col, logic [7:0] row);
        int          uw;
        int          uh;
        int          div;
        int          k;
        int          cx;
        int          ry;
        int          acc_r;
        int          acc_g;
        int          acc_b;
        logic [23:0] px;
        rgb_t        res;
        uw = used_span(width_reg);
        uh = used_span(height_reg);
        div = 0;
        acc_r = (mode_reg == MODE_NEGATIVE) ? 256 : 0;
        acc_g = acc_r;
        acc_b = acc_r;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                k = TAPS[mode_reg][a][b];
                cx = edge_clamp(int'(col) + a - 1, uw);
                ry = edge_clamp(int'(row) + b - 1, uh);
                px = frame[ry * 256 + cx];
                acc_r += k * int'(px[23:16]);
                acc_g += k * int'(px[15:8]);
                acc_b += k * int'(px[7:0]);
                div += k;
            end
        end
        if (div < 1) begin
            div = 1;
        end
        res.red = scale_channel(acc_r, div);
        res.green = scale_channel(acc_g, div);
        res.blue = scale_channel(acc_b, div);
        return res;
    endfunction

    task automatic compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        pixel_req_t req;
        rgb_t       got;
        rgb_t       exp_px;
        if (!aresetn) begin
            mode_reg = MODE_BLUR;
            width_reg = 9'd256;
            height_reg = 9'd256;
            filtered_due.delete();
            errors = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_MODE:   mode_reg = pwdata[2:0];
                    ADDR_WIDTH:  width_reg = pwdata[8:0];
                    ADDR_HEIGHT: height_reg = pwdata[8:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = rgb_t'(m_tdata);
                if (filtered_due.size() == 0) begin
                    $error("result transaction with no filtered pixel outstanding: %h", m_tdata);
                    errors++;
                end else begin
                    exp_px = filtered_due.pop_front();
                    compare_field("red_out", exp_px.red, got.red);
                    compare_field("green_out", exp_px.green, got.green);
                    compare_field("blue_out", exp_px.blue, got.blue);
                end
            end
            if (s_tvalid && s_tready) begin
                req = pixel_req_t'(s_tdata);
                if (s_tuser == OP_STORE) begin
                    frame[{req.row, req.column}] = {req.red, req.green, req.blue};
                end else begin
                    filtered_due.push_back(filter_pixel(req.column, req.row));
                end
            end
        end
        pending = filtered_due.size();
    end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the convolution core: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb_top;
    import ikc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 97;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;  // column, row, red_in, green_in, blue_in
    logic        s_tuser;  // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;  // red_out, green_out, blue_out
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int pending;
    int errors;
    int cycles;
    int items_sent;
    int burst_left;
    int use_w;
    int use_h;
    int win_col;
    int win_row;
    bit hold_req;
    bit written [0:65535];

    image_kernel_convolution_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    conv_checker u_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .pending  (pending),
        .errors   (errors)
    );

    initial begin
        aclk = 1'b0;
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int used_span(logic [8:0] v);
        int n;
        n = int'(v);
        if (n == 0) begin
            n = 1;
        end else if (n > 256) begin
            n = 256;
        end
        return n;
    endfunction

    function automatic int edge_clamp(int v, int lim);
        int r;
        r = v;
        if (r < 0) begin
            r = 0;
        end else if (r > lim - 1) begin
            r = lim - 1;
        end
        return r;
    endfunction

    // Extremes weighted up so saturation and negative of zero come often.
    function automatic logic [7:0] chan_value();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) begin
            return 8'd0;
        end else if (sel == 1) begin
            return 8'd255;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [8:0] pick_size();
        case ($urandom_range(0, 4))
            0:       return 9'd1;
            1:       return 9'd256;
            2:       return 9'($urandom_range(2, 8));
            3:       return 9'($urandom_range(9, 64));
            default: return 9'($urandom_range(65, 255));
        endcase
    endfunction

    task automatic push_item(input logic op, input logic [7:0] col, input logic [7:0] row,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tuser = op;
        s_tdata = {b, g, r, row, col};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic store_px(input logic [7:0] col, input logic [7:0] row,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        written[{row, col}] = 1'b1;
        push_item(OP_STORE, col, row, r, g, b);
    endtask

    // Any neighbour never written is stored first, so no read hits an empty entry.
    task automatic compute_px(input logic [7:0] col, input logic [7:0] row);
        int cx;
        int ry;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                cx = edge_clamp(int'(col) + a - 1, use_w);
                ry = edge_clamp(int'(row) + b - 1, use_h);
                if (!written[ry * 256 + cx]) begin
                    store_px(8'(cx), 8'(ry), chan_value(), chan_value(), chan_value());
                end
            end
        end
        push_item(OP_COMPUTE, col, row, chan_value(), chan_value(), chan_value());
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = addr;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_phase(input logic [2:0] mode, input logic [8:0] w, input logic [8:0] h);
        drain();
        apb_write(ADDR_MODE, {29'b0, mode});
        apb_write(ADDR_WIDTH, {23'b0, w});
        apb_write(ADDR_HEIGHT, {23'b0, h});
        use_w = used_span(w);
        use_h = used_span(h);
        win_col = $urandom_range(0, use_w - 1);
        win_row = $urandom_range(0, use_h - 1);
    endtask

    // Mostly a hot window at the image so neighbourhoods get reused; some anywhere.
    task automatic random_items(input int n);
        int         stop;
        int         c;
        int         r;
        logic [7:0] col;
        logic [7:0] row;
        stop = items_sent + n;
        while (items_sent < stop) begin
            if ($urandom_range(0, 9) < 2) begin
                col = 8'($urandom_range(0, 255));
                row = 8'($urandom_range(0, 255));
            end else begin
                c = win_col + $urandom_range(0, 7);
                r = win_row + $urandom_range(0, 7);
                col = (c > 255) ? 8'd255 : 8'(c);
                row = (r > 255) ? 8'd255 : 8'(r);
            end
            if ($urandom_range(0, 99) < 45) begin
                compute_px(col, row);
            end else begin
                store_px(col, row, chan_value(), chan_value(), chan_value());
            end
        end
    endtask

    // Receiver stall pattern, with one long hold-off on request.
    initial begin
        int seg_left;
        int style;
        bit held;
        m_tready = 1'b0;
        seg_left = 0;
        style = 0;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (seg_left == 0) begin
                style = $urandom_range(0, 3);
                seg_left = $urandom_range(8, 80);
            end
            seg_left--;
            case (style)
                0:       m_tready = 1'b1;
                1:       m_tready = 1'($urandom_range(0, 1));
                2:       m_tready = ($urandom_range(0, 4) == 0);
                default: m_tready = !m_tready;
            endcase
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = OP_STORE;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        items_sent = 0;
        burst_left = 0;
        hold_req = 1'b0;
        use_w = 256;
        use_h = 256;
        win_col = 0;
        win_row = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // after reset: blur over 256x256, corners and channel extremes
        store_px(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        store_px(8'd1, 8'd1, 8'd255, 8'd255, 8'd255);
        store_px(8'd255, 8'd255, 8'd255, 8'd0, 8'd255);
        store_px(8'd254, 8'd254, 8'haa, 8'h55, 8'h0f);
        compute_px(8'd0, 8'd0);
        compute_px(8'd255, 8'd255);
        compute_px(8'd255, 8'd0);

        set_phase(MODE_SHARPEN, 9'd16, 9'd12);
        random_items(PHASE_ITEMS);
        set_phase(MODE_EMBOSS, 9'd1, 9'd1);
        random_items(PHASE_ITEMS);
        set_phase(MODE_NEGATIVE, 9'd256, 9'd256);
        hold_req = 1'b1;
        random_items(PHASE_ITEMS);
        set_phase(MODE_LIGHT_BLUR, 9'd3, 9'd256);
        random_items(PHASE_ITEMS);
        set_phase(MODE_LIGHT_SHARP, 9'd256, 9'd1);
        random_items(PHASE_ITEMS);
        set_phase(MODE_LIGHT_EMB, 9'd40, 9'd9);
        random_items(PHASE_ITEMS);
        set_phase(MODE_SPARE, 9'd7, 9'd5);
        random_items(PHASE_ITEMS);
        // zero size reads as one, oversize as the full store
        set_phase(MODE_BLUR, 9'd0, 9'd300);
        random_items(PHASE_ITEMS);
        set_phase(MODE_SHARPEN, 9'd511, 9'd0);
        random_items(PHASE_ITEMS);
        for (int p = 0; p < 6; p++) begin
            set_phase(3'($urandom_range(0, 7)), pick_size(), pick_size());
            random_items(PHASE_ITEMS);
        end

        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/ikc_pkg.sv
hdl/ikc_frame_mem.sv
hdl/ikc_mac.sv
hdl/image_kernel_convolution_core.sv
test/conv_checker.sv
test/tb_top.sv
